@@ hw/rtl/rrsp_pkg.sv @@
// ----------------------------------------------------------------------------
// rrsp_pkg
// Shared types and constants for the reply stream parser.
// ----------------------------------------------------------------------------
package rrsp_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_LOAD,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LINE,
        PH_LINE_CR,
        PH_PAY,
        PH_PAY_CR,
        PH_SKIP
    } t_phase;

    localparam logic [2:0] TY_ERROR   = 3'd0;
    localparam logic [2:0] TY_STATUS  = 3'd1;
    localparam logic [2:0] TY_INTEGER = 3'd2;
    localparam logic [2:0] TY_STRING  = 3'd3;
    localparam logic [2:0] TY_ARRAY   = 3'd4;

    localparam logic [2:0] SS_BUSY     = 3'd0;
    localparam logic [2:0] SS_DONE     = 3'd1;
    localparam logic [2:0] SS_EARLY    = 3'd2;
    localparam logic [2:0] SS_BAD_TYPE = 3'd3;
    localparam logic [2:0] SS_LEN_MISM = 3'd4;
    localparam logic [2:0] SS_DEEP     = 3'd5;

    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int LEN_OUT_W = 15;

    typedef struct packed {
        logic accept;
        logic pop;
        logic load;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic need_pop;
        logic pop_load;
        logic out_busy;
    } t_dstat;

endpackage

@@ hw/rtl/resp_reply_stream_parser.sv @@
// ----------------------------------------------------------------------------
// resp_reply_stream_parser
// Byte-serial parser for one typed, line-oriented reply per buffer.
// ----------------------------------------------------------------------------
// The slave channel takes one buffer byte per word in tdata, with tlast on the
// final byte of a buffer. The master channel returns one word per completed
// element, per opened array header or per change of reply status; bytes that
// cause nothing return no word. The master tuser carries the element flag and
// the element type. A byte is accepted and parsed in the idle state, and its
// result is finished into the output register in the finish state. When an
// element completes inside open arrays, each level that it is counted against
// adds a pop step, and each level that it closes below the outermost adds a
// load step to reload the parent count from the stack memory.
// The next byte is accepted while a result still waits in the output
// register. A stalled receiver holds the finish step, and with it the input,
// until that register is free; nothing is lost.
// Reset returns the parser to the start of a reply with an empty stack; the
// stack memory itself is not cleared.
// ----------------------------------------------------------------------------
module resp_reply_stream_parser #(
    parameter int MAX_DEPTH   = 8,
    parameter int COUNT_WIDTH = 32,
    parameter int MAX_LINE    = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,   // elem_value, line_length, elem_depth, status
    output logic [3:0]  o_m_tuser    // has_element, elem_type
);

    rrsp_pkg::t_cmd   cmd;
    rrsp_pkg::t_dstat dstat;
    logic             has;
    logic [2:0]       etype;
    logic [63:0]      value;
    logic [14:0]      llen;
    logic [3:0]       depth;
    logic [2:0]       status;

    rrsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_stat     (dstat),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    rrsp_dpath #(
        .MAX_DEPTH   (MAX_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .MAX_LINE    (MAX_LINE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_cmd       (cmd),
        .o_stat      (dstat),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_has       (has),
        .o_type      (etype),
        .o_value     (value),
        .o_llen      (llen),
        .o_depth     (depth),
        .o_status    (status)
    );

    assign o_m_tdata = {2'b00, status, depth, llen, value};
    assign o_m_tuser = {etype, has};

    a_no_elem_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[85:83] != rrsp_pkg::SS_BUSY))
        else $error("word without element carries no status");

    a_no_elem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[82:0] == '0))
        else $error("word without element has nonzero element fields");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("byte accepted while previous byte still in work");

endmodule

@@ hw/rtl/rrsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrsp_ctrl
// Sequencer for accepting a word, unwinding array levels and finishing.
// ----------------------------------------------------------------------------
module rrsp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  rrsp_pkg::t_dstat i_stat,
    output logic            o_in_ready,
    output rrsp_pkg::t_cmd  o_cmd
);

    rrsp_pkg::t_state r_state;
    rrsp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrsp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rrsp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_stat.need_pop ? rrsp_pkg::ST_POP : rrsp_pkg::ST_FIN;
                end
            end
            rrsp_pkg::ST_POP: begin
                o_cmd.pop = 1'b1;
                n_state = i_stat.pop_load ? rrsp_pkg::ST_LOAD : rrsp_pkg::ST_FIN;
            end
            rrsp_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state = rrsp_pkg::ST_POP;
            end
            rrsp_pkg::ST_FIN: begin
                if (!i_stat.out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_state = rrsp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rrsp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/rrsp_dpath.sv @@
// ----------------------------------------------------------------------------
// rrsp_dpath
// Line parser, array count stack and output register.
// ----------------------------------------------------------------------------
module rrsp_dpath #(
    parameter int MAX_DEPTH   = 8,
    parameter int COUNT_WIDTH = 32,
    parameter int MAX_LINE    = 16384
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  rrsp_pkg::t_cmd   i_cmd,
    output rrsp_pkg::t_dstat o_stat,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic             o_has,
    output logic [2:0]       o_type,
    output logic [63:0]      o_value,
    output logic [14:0]      o_llen,
    output logic [3:0]       o_depth,
    output logic [2:0]       o_status
);

    localparam int LC_W  = $clog2(MAX_LINE + 1);
    localparam int LVL_W = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [LC_W-1:0]  LINE_SAT = LC_W'(MAX_LINE);
    localparam logic [LVL_W-1:0] LVL_MAX  = LVL_W'(MAX_DEPTH);

    rrsp_pkg::t_phase r_phase, n_phase;
    logic [2:0]             r_cur_type, n_cur_type;
    logic [63:0]            r_accum, n_accum;
    logic                   r_neg, n_neg;
    logic                   r_bad, n_bad;
    logic                   r_stop, n_stop;
    logic [63:0]            r_decl, n_decl;
    logic [LC_W-1:0]        r_count, n_count;
    logic [LVL_W-1:0]       r_level, n_level;
    logic [COUNT_WIDTH-1:0] r_top, n_top;
    logic [COUNT_WIDTH-1:0] r_mem [MAX_DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd;

    logic                   r_p_has, n_p_has;
    logic                   n_p_cpl;
    logic [2:0]             r_p_type, n_p_type;
    logic [63:0]            r_p_val, n_p_val;
    logic [LC_W-1:0]        r_p_llen, n_p_llen;
    logic [LVL_W-1:0]       r_p_depth, n_p_depth;
    logic [2:0]             r_p_base, n_p_base;
    logic                   r_p_last, r_p_skip, r_done, n_done;
    logic                   push;

    logic                   r_out_valid;
    logic                   r_has;
    logic [2:0]             r_type;
    logic [63:0]            r_value;
    logic [14:0]            r_llen;
    logic [3:0]             r_depth;
    logic [2:0]             r_status;

    logic                   is_cr, is_lf, is_digit, plain, cr_ph, in_line, in_pay;
    logic [7:0]             tc;
    logic [LC_W-1:0]        cnt1;
    logic [63:0]            num;
    logic [63:0]            acc10;
    logic [COUNT_WIDTH-1:0] dec;
    logic [2:0]             fin_status;
    logic [63:0]            llen64;

    always_comb begin
        is_cr    = (i_byte == rrsp_pkg::CH_CR);
        is_lf    = (i_byte == rrsp_pkg::CH_LF);
        in_line  = (r_phase == rrsp_pkg::PH_LINE) || (r_phase == rrsp_pkg::PH_LINE_CR);
        in_pay   = (r_phase == rrsp_pkg::PH_PAY) || (r_phase == rrsp_pkg::PH_PAY_CR);
        cr_ph    = (r_phase == rrsp_pkg::PH_LINE_CR) || (r_phase == rrsp_pkg::PH_PAY_CR);
        plain    = !cr_ph;
        tc       = plain ? i_byte : rrsp_pkg::CH_CR;
        is_digit = (tc >= rrsp_pkg::CH_ZERO) && (tc <= rrsp_pkg::CH_NINE);
        acc10    = (r_accum << 3) + (r_accum << 1) + 64'(tc - rrsp_pkg::CH_ZERO);
        num      = r_bad ? '1 : (r_neg ? (64'd0 - r_accum) : r_accum);
        cnt1     = (r_count < LINE_SAT) ? r_count + LC_W'(1) : r_count;
        dec      = (r_top != '0) ? r_top - COUNT_WIDTH'(1) : r_top;

        n_phase    = r_phase;
        n_cur_type = r_cur_type;
        n_accum    = r_accum;
        n_neg      = r_neg;
        n_bad      = r_bad;
        n_stop     = r_stop;
        n_decl     = r_decl;
        n_count    = r_count;
        n_level    = r_level;
        n_top      = r_top;
        n_p_has    = 1'b0;
        n_p_cpl    = 1'b0;
        n_p_type   = rrsp_pkg::TY_ERROR;
        n_p_val    = '0;
        n_p_llen   = '0;
        n_p_depth  = '0;
        n_p_base   = rrsp_pkg::SS_BUSY;
        n_done     = 1'b0;
        push       = 1'b0;

        if (r_phase == rrsp_pkg::PH_TYPE) begin
            n_cur_type = rrsp_pkg::TY_ERROR;
            case (i_byte)
                rrsp_pkg::CH_MINUS:  n_cur_type = rrsp_pkg::TY_ERROR;
                rrsp_pkg::CH_PLUS:   n_cur_type = rrsp_pkg::TY_STATUS;
                rrsp_pkg::CH_COLON:  n_cur_type = rrsp_pkg::TY_INTEGER;
                rrsp_pkg::CH_DOLLAR: n_cur_type = rrsp_pkg::TY_STRING;
                rrsp_pkg::CH_STAR:   n_cur_type = rrsp_pkg::TY_ARRAY;
                default:             n_p_base   = rrsp_pkg::SS_BAD_TYPE;
            endcase
            if (n_p_base != rrsp_pkg::SS_BUSY) begin
                n_cur_type = r_cur_type;
            end else begin
                n_phase = rrsp_pkg::PH_LINE;
                n_accum = '0;
                n_neg   = 1'b0;
                n_bad   = 1'b0;
                n_stop  = 1'b0;
                n_count = '0;
            end
        end else if (in_line || in_pay) begin
            if (plain && is_cr) begin
                n_phase = in_line ? rrsp_pkg::PH_LINE_CR : rrsp_pkg::PH_PAY_CR;
            end else if (cr_ph && is_lf) begin
                n_p_depth = r_level;
                if (in_pay) begin
                    if (r_decl == 64'(r_count)) begin
                        n_p_cpl  = 1'b1;
                        n_p_type = rrsp_pkg::TY_STRING;
                        n_p_val  = r_decl;
                        n_p_llen = r_count;
                    end else begin
                        n_p_base = rrsp_pkg::SS_LEN_MISM;
                    end
                end else if ((r_cur_type == rrsp_pkg::TY_ERROR) ||
                             (r_cur_type == rrsp_pkg::TY_STATUS)) begin
                    n_p_cpl  = 1'b1;
                    n_p_type = r_cur_type;
                    n_p_llen = r_count;
                end else if (r_cur_type == rrsp_pkg::TY_INTEGER) begin
                    n_p_cpl  = 1'b1;
                    n_p_type = rrsp_pkg::TY_INTEGER;
                    n_p_val  = num;
                end else if (r_cur_type == rrsp_pkg::TY_STRING) begin
                    n_decl  = num;
                    n_phase = rrsp_pkg::PH_PAY;
                    n_accum = '0;
                    n_neg   = 1'b0;
                    n_bad   = 1'b0;
                    n_stop  = 1'b0;
                    n_count = '0;
                end else if (!num[63] && (num != '0)) begin
                    if (r_level >= LVL_MAX) begin
                        n_p_base = rrsp_pkg::SS_DEEP;
                    end else begin
                        push     = 1'b1;
                        n_top    = ((num >> COUNT_WIDTH) != '0) ? '1 : num[COUNT_WIDTH-1:0];
                        n_level  = r_level + LVL_W'(1);
                        n_p_has  = 1'b1;
                        n_p_type = rrsp_pkg::TY_ARRAY;
                        n_p_val  = num;
                        n_phase  = rrsp_pkg::PH_TYPE;
                    end
                end else begin
                    n_p_cpl  = 1'b1;
                    n_p_type = rrsp_pkg::TY_ARRAY;
                    n_p_val  = num;
                end
            end else begin
                n_count = cnt1;
                if (!r_stop && !r_bad) begin
                    if (tc == rrsp_pkg::CH_CR) begin
                        n_stop = 1'b1;
                    end else if ((r_count == '0) && (tc == rrsp_pkg::CH_MINUS)) begin
                        n_neg = 1'b1;
                    end else if ((r_count == '0) && (tc == rrsp_pkg::CH_PLUS)) begin
                        n_neg = r_neg;
                    end else if (is_digit) begin
                        n_accum = acc10;
                    end else begin
                        n_bad = 1'b1;
                    end
                end
                if (cr_ph && !is_cr) begin
                    n_count = (cnt1 < LINE_SAT) ? cnt1 + LC_W'(1) : cnt1;
                    n_phase = in_line ? rrsp_pkg::PH_LINE : rrsp_pkg::PH_PAY;
                end
            end
            if (n_p_cpl) begin
                n_p_has = 1'b1;
                n_phase = rrsp_pkg::PH_TYPE;
                n_done  = (r_level == '0);
            end
        end
    end

    always_comb begin
        if (r_p_skip) begin
            fin_status = rrsp_pkg::SS_BUSY;
        end else if (r_p_base != rrsp_pkg::SS_BUSY) begin
            fin_status = r_p_base;
        end else if (r_done) begin
            fin_status = rrsp_pkg::SS_DONE;
        end else if (r_p_last) begin
            fin_status = rrsp_pkg::SS_EARLY;
        end else begin
            fin_status = rrsp_pkg::SS_BUSY;
        end
        llen64 = 64'(r_p_llen);
    end

    always_comb begin
        o_stat.need_pop = n_p_cpl && (r_level != '0);
        o_stat.pop_load = (dec == '0) && (r_level != LVL_W'(1));
        o_stat.out_busy = r_out_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[IDX_W'(r_level - LVL_W'(2))];
        if (i_cmd.accept && push && (r_level != '0)) begin
            r_mem[IDX_W'(r_level - LVL_W'(1))] <= r_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rrsp_pkg::PH_TYPE;
            r_cur_type  <= rrsp_pkg::TY_ERROR;
            r_accum     <= '0;
            r_neg       <= 1'b0;
            r_bad       <= 1'b0;
            r_stop      <= 1'b0;
            r_decl      <= '0;
            r_count     <= '0;
            r_level     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.accept) begin
                r_p_last <= i_last;
                r_p_skip <= (r_phase == rrsp_pkg::PH_SKIP);
                if (r_phase != rrsp_pkg::PH_SKIP) begin
                    r_phase    <= n_phase;
                    r_cur_type <= n_cur_type;
                    r_accum    <= n_accum;
                    r_neg      <= n_neg;
                    r_bad      <= n_bad;
                    r_stop     <= n_stop;
                    r_decl     <= n_decl;
                    r_count    <= n_count;
                    r_level    <= n_level;
                    r_top      <= n_top;
                end
                r_p_has   <= n_p_has;
                r_p_type  <= n_p_type;
                r_p_val   <= n_p_val;
                r_p_llen  <= n_p_llen;
                r_p_depth <= n_p_depth;
                r_p_base  <= (r_phase == rrsp_pkg::PH_SKIP) ? rrsp_pkg::SS_BUSY : n_p_base;
                r_done    <= (r_phase != rrsp_pkg::PH_SKIP) && n_done;
            end
            if (i_cmd.pop) begin
                if (dec != '0) begin
                    r_top <= dec;
                end else begin
                    r_level <= r_level - LVL_W'(1);
                    if (r_level == LVL_W'(1)) begin
                        r_done <= 1'b1;
                    end
                end
            end
            if (i_cmd.load) begin
                r_top <= r_rd;
            end
            if (i_cmd.fin) begin
                if (fin_status != rrsp_pkg::SS_BUSY) begin
                    r_phase <= r_p_last ? rrsp_pkg::PH_TYPE : rrsp_pkg::PH_SKIP;
                    r_level <= '0;
                end else if (r_p_last) begin
                    r_phase <= rrsp_pkg::PH_TYPE;
                    r_level <= '0;
                end
                if (!r_p_skip && (r_p_has || (fin_status != rrsp_pkg::SS_BUSY))) begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_has    <= r_p_has;
            r_type   <= r_p_has ? r_p_type : rrsp_pkg::TY_ERROR;
            r_value  <= r_p_has ? r_p_val : '0;
            r_llen   <= r_p_has ? llen64[14:0] : '0;
            r_depth  <= r_p_has ? 4'(r_p_depth) : '0;
            r_status <= fin_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_has       = r_has;
    assign o_type      = r_type;
    assign o_value     = r_value;
    assign o_llen      = r_llen;
    assign o_depth     = r_depth;
    assign o_status    = r_status;

endmodule
